// ===== rtl/deq_pkg.sv =====
package deq_pkg;

  localparam int unsigned DEPTH       = 256;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned ADDR_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W       = $clog2(DEPTH + 1);
  localparam int unsigned OP_W        = 2;
  localparam int unsigned STAT_W      = 2;
  localparam int unsigned IN_FIELDS_W  = OP_W + DATA_W;
  localparam int unsigned OUT_FIELDS_W = DATA_W + STAT_W + CNT_W + 1;
  localparam int unsigned IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_BACK  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_POP
  } state_t;

  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    return (p == ADDR_W'(DEPTH - 1)) ? '0 : p + ADDR_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] ptr_dec(input logic [ADDR_W-1:0] p);
    return (p == '0) ? ADDR_W'(DEPTH - 1) : p - ADDR_W'(1);
  endfunction

endpackage

// ===== rtl/double_ended_queue.sv =====
// Channel  Dir  tdata fields (low bit up)                        Handshake
// in_      in   op[1:0], push_value[33:2]                         tvalid/tready
// out_     out  pop_value[31:0], status[33:32],                   tvalid/tready
//               element_count[42:34], is_empty[43]
//
// Push, failed pop and dropped push: result loaded on accept. Successful pop:
// via S_POP, set by the registered read of the single-port element RAM.
// Reset clears pointers, count, state and result valid; the RAM is not cleared.
// in_tready is low while a pop read is outstanding or the result register is
// full and not being taken.
module double_ended_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [deq_pkg::IN_TDATA_W-1:0]    in_tdata,   // op, push_value
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [deq_pkg::OUT_TDATA_W-1:0]   out_tdata   // pop_value, status,
                                                        // element_count, is_empty
);
  import deq_pkg::*;

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   front_r, front_nxt;
  logic [ADDR_W-1:0]   back_r, back_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_value_r, out_value_nxt;
  status_t             out_status_r, out_status_nxt;
  logic [CNT_W-1:0]    out_count_r, out_count_nxt;
  logic                out_empty_r, out_empty_nxt;

  op_t                 in_op;
  logic [DATA_W-1:0]   in_value;
  logic                accept;
  logic                full;
  logic                empty;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [DATA_W-1:0]   ram_rdata;

  assign in_op    = op_t'(in_tdata[OP_W-1:0]);
  assign in_value = in_tdata[OP_W +: DATA_W];
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  assign in_tready = (state_r == S_IDLE) && (!out_valid_r || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt      = state_r;
    front_nxt      = front_r;
    back_nxt       = back_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    out_count_nxt  = out_count_r;
    out_empty_nxt  = out_empty_r;
    ram_we         = 1'b0;
    ram_addr       = front_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_value_nxt = '0;
          case (in_op)
            OP_PUSH_FRONT, OP_PUSH_BACK: begin
              if (full) begin
                out_status_nxt = ST_FULL;
              end else begin
                ram_we         = 1'b1;
                out_status_nxt = ST_OK;
                count_nxt      = count_r + CNT_W'(1);
                if (in_op == OP_PUSH_FRONT) begin
                  front_nxt = ptr_dec(front_r);
                  ram_addr  = ptr_dec(front_r);
                end else begin
                  back_nxt = ptr_inc(back_r);
                  ram_addr = back_r;
                end
              end
              out_valid_nxt = 1'b1;
              out_count_nxt = count_nxt;
              out_empty_nxt = (count_nxt == '0);
            end
            OP_POP_FRONT, OP_POP_BACK: begin
              if (empty) begin
                out_status_nxt = ST_EMPTY;
                out_valid_nxt  = 1'b1;
                out_count_nxt  = count_r;
                out_empty_nxt  = 1'b1;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                state_nxt = S_POP;
                if (in_op == OP_POP_FRONT) begin
                  front_nxt = ptr_inc(front_r);
                  ram_addr  = front_r;
                end else begin
                  back_nxt = ptr_dec(back_r);
                  ram_addr = ptr_dec(back_r);
                end
              end
            end
            default: begin
              out_status_nxt = ST_OK;
            end
          endcase
        end
      end
      S_POP: begin
        out_valid_nxt  = 1'b1;
        out_value_nxt  = ram_rdata;
        out_status_nxt = ST_OK;
        out_count_nxt  = count_r;
        out_empty_nxt  = (count_r == '0);
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      front_r     <= '0;
      back_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      front_r     <= front_nxt;
      back_r      <= back_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_count_r  <= out_count_nxt;
    out_empty_r  <= out_empty_nxt;
  end

  deq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_value),
    .rdata (ram_rdata)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_empty_r, out_count_r, out_status_r, out_value_r});

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("held count above depth");

  a_ptrs_meet: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 || count_r == CNT_W'(DEPTH)) |-> (front_r == back_r))
    else $error("pointers disagree with count");

  a_pop_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |-> !out_valid_r)
    else $error("pop result would overwrite pending item");

  a_pop_read: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == OP_POP_FRONT || in_op == OP_POP_BACK) && !empty)
      |=> (state_r == S_POP))
    else $error("pop did not start RAM read");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_count_r == '0)))
    else $error("empty flag mismatch");
`endif

endmodule

// ===== rtl/deq_ram.sv =====
module deq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [DATA_W-1:0] pop_value;
    status_t           status;
    logic [CNT_W-1:0]  element_count;
    logic              is_empty;
  } deq_result_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [DATA_W-1:0] model_store [DEPTH];
  logic [ADDR_W-1:0] model_front = '0;
  logic [ADDR_W-1:0] model_back  = '0;
  logic [CNT_W-1:0]  model_count = '0;

  deq_result_t pending_results [$];
  int error_count = 0;
  int cycle_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;

  double_ended_queue dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic deq_result_t apply_deque_op(op_t op, logic [DATA_W-1:0] value);
    deq_result_t r;
    r.pop_value = '0;
    r.status    = ST_OK;
    if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK) begin
      if (model_count == CNT_W'(DEPTH)) begin
        r.status = ST_FULL;
      end else if (op == OP_PUSH_FRONT) begin
        model_front = (model_front == '0) ? ADDR_W'(DEPTH - 1) : model_front - ADDR_W'(1);
        model_store[model_front] = value;
        model_count = model_count + CNT_W'(1);
      end else begin
        model_store[model_back] = value;
        model_back  = (model_back == ADDR_W'(DEPTH - 1)) ? '0 : model_back + ADDR_W'(1);
        model_count = model_count + CNT_W'(1);
      end
    end else begin
      if (model_count == '0) begin
        r.status = ST_EMPTY;
      end else if (op == OP_POP_FRONT) begin
        r.pop_value = model_store[model_front];
        model_front = (model_front == ADDR_W'(DEPTH - 1)) ? '0 : model_front + ADDR_W'(1);
        model_count = model_count - CNT_W'(1);
      end else begin
        model_back  = (model_back == '0) ? ADDR_W'(DEPTH - 1) : model_back - ADDR_W'(1);
        r.pop_value = model_store[model_back];
        model_count = model_count - CNT_W'(1);
      end
    end
    r.element_count = model_count;
    r.is_empty      = (model_count == '0);
    return r;
  endfunction

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    deq_result_t got;
    deq_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pop_value     = out_tdata[DATA_W-1:0];
      got.status        = status_t'(out_tdata[DATA_W +: STAT_W]);
      got.element_count = out_tdata[DATA_W+STAT_W +: CNT_W];
      got.is_empty      = out_tdata[DATA_W+STAT_W+CNT_W];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, out_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("pop_value", 64'(want.pop_value), 64'(got.pop_value));
        compare_field("status", 64'(want.status), 64'(got.status));
        compare_field("element_count", 64'(want.element_count), 64'(got.element_count));
        compare_field("is_empty", 64'(want.is_empty), 64'(got.is_empty));
      end
    end
    out_tready <= (int'($urandom_range(99)) >= stall_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // hold each item until accepted; valid stays high into the next call
  task automatic send_item(op_t op, logic [DATA_W-1:0] value);
    while (int'($urandom_range(99)) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({value, op});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(apply_deque_op(op, value));
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_directed_ops();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_BACK, '1);
    send_item(OP_PUSH_FRONT, '1);
    send_item(OP_PUSH_BACK, '0);
    send_item(OP_PUSH_FRONT, 32'h0000_0001);
    send_item(OP_PUSH_BACK, 32'h8000_0000);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, '1);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_PUSH_BACK, 32'hA5A5_A5A5);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_PUSH_FRONT, 32'h5A5A_5A5A);
    send_item(OP_POP_BACK, '0);
    send_item(OP_PUSH_BACK, 32'h7FFF_FFFF);
    send_item(OP_POP_BACK, '0);
    send_item(OP_PUSH_FRONT, 32'hFFFF_FFFE);
    send_item(OP_POP_FRONT, '0);
  endtask

  task automatic test_full_and_wrap();
    idle_pct  = 23;
    stall_pct = 23;
    for (int i = 0; i < DEPTH; i++) begin
      send_item($urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK, $urandom);
    end
    send_item(OP_PUSH_FRONT, '1);
    send_item(OP_PUSH_BACK, '0);
    send_item(OP_POP_FRONT, '0);
    send_item(OP_PUSH_BACK, $urandom);
    send_item(OP_PUSH_FRONT, $urandom);
    send_item(OP_POP_BACK, '0);
    send_item(OP_PUSH_FRONT, $urandom);
    send_item(OP_PUSH_BACK, $urandom);
    for (int i = 0; i < DEPTH; i++) begin
      send_item($urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
    end
    send_item(OP_POP_FRONT, '0);
    send_item(OP_POP_BACK, '0);
  endtask

  task automatic test_random_ops(int n_items, int idle, int stall);
    int          push_bias = 50;
    int          run_left  = 0;
    op_t         op;
    logic [DATA_W-1:0] value;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(160, 32);
        case ($urandom_range(4))
          0: push_bias = 90;
          1: push_bias = 65;
          2: push_bias = 50;
          3: push_bias = 35;
          default: push_bias = 10;
        endcase
      end
      run_left--;
      if (int'($urandom_range(99)) < push_bias) begin
        op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
      end else begin
        op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
      end
      case ($urandom_range(15))
        0: value = '0;
        1: value = '1;
        default: value = $urandom;
      endcase
      send_item(op, value);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_ops();
    test_full_and_wrap();
    wait_for_results();
    test_random_ops(320, 0, 0);
    test_random_ops(320, 53, 0);
    wait_for_results();
    test_random_ops(320, 0, 53);
    test_random_ops(320, 23, 23);
    wait_for_results();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
